// ----- design/utb_pkg.sv -----
package utb_pkg;

  // field types of the command and result beats
  typedef logic [2:0] action_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [8:0] len_t;
  typedef logic [6:0] count_t;

  // action codes
  localparam action_t ACT_INSERT = 3'd0;
  localparam action_t ACT_DELETE = 3'd1;
  localparam action_t ACT_UNDO   = 3'd2;
  localparam action_t ACT_REDO   = 3'd3;
  localparam action_t ACT_READ   = 3'd4;

  // status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;
  localparam status_t STAT_EMPTY = 2'd3;

  // kind of a recorded edit
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    action_t action;
    byte_t   position;
    byte_t   char_in;
  } cmd_t;

  typedef struct packed {
    status_t status;
    byte_t   char_out;
    byte_t   pos_out;
    len_t    doc_length;
    count_t  undo_count;
    count_t  redo_count;
  } result_t;

  // one history entry
  typedef struct packed {
    logic  kind;
    byte_t pos;
    byte_t ch;
  } hist_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_APPLY,
    S_TAKE_WAIT,
    S_SHIFT,
    S_PUT_LAST,
    S_READ_WAIT,
    S_COMMIT
  } state_t;

endpackage

// ----- design/undoable_text_buffer.sv -----
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------------------------
// command  | in        | start high, busy low      | cmd (action, position, char_in)
// result   | out       | done high for one cycle   | result (status, bytes, length, counts)
//
// one command at a time; busy rises at the accepting edge and drops as done rises
// insert moves the tail after the position right, delete moves it left, append writes directly;
// reads, errors, empty stacks and unknown actions finish without a shift;
// undo and redo fetch their history entry first; the shift moves one byte per cycle
// rst is synchronous; it clears the lengths and stack counts, the rams are not cleared
// done marks a one-cycle result beat; the receiver cannot stall it
module undoable_text_buffer #(
  parameter int DOC_DEPTH     = 256,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  utb_pkg::cmd_t    cmd,
  output logic             done,
  output utb_pkg::result_t result
);

  // document address, document length, history address and history count widths
  localparam int AW = $clog2(DOC_DEPTH);
  localparam int LW = $clog2(DOC_DEPTH + 1);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = $bits(utb_pkg::hist_t);

  // sequencer state
  utb_pkg::state_t  state, state_next;
  utb_pkg::action_t op, op_next;
  utb_pkg::byte_t   cur_pos, cur_pos_next;
  utb_pkg::byte_t   cur_ch, cur_ch_next;
  logic             ent_kind, ent_kind_next;
  logic             put_op, put_op_next;      // 1: put a byte, 0: take a byte
  logic [LW-1:0]    idx, idx_next;            // shift cursor

  // architectural state kept in registers
  logic [LW-1:0]    length, length_next;
  logic [HW-1:0]    undo_base, undo_base_next;
  logic [CW-1:0]    undo_size, undo_size_next;
  logic [CW-1:0]    redo_size, redo_size_next;

  utb_pkg::result_t result_next;
  logic             done_next;

  // ram ports
  logic             doc_we;
  logic [AW-1:0]    doc_waddr, doc_raddr;
  utb_pkg::byte_t   doc_wdata, doc_rdata;
  logic             undo_we;
  logic [HW-1:0]    undo_waddr, undo_raddr;
  logic [EW-1:0]    undo_wdata, undo_rdata;
  logic             redo_we;
  logic [HW-1:0]    redo_waddr, redo_raddr;
  logic [EW-1:0]    redo_wdata, redo_rdata;

  // finishing a command
  logic             fin;
  utb_pkg::status_t fin_status;
  utb_pkg::byte_t   fin_ch;
  utb_pkg::byte_t   fin_pos;

  // undo ring helpers
  logic             undo_full;
  logic [HW-1:0]    push_base;
  logic [CW-1:0]    push_cnt;
  logic [HW-1:0]    push_slot;
  logic [HW-1:0]    undo_top_slot;
  utb_pkg::hist_t   fetched;

  // (b + k) mod HISTORY_DEPTH, with b + k below twice the depth
  function automatic logic [HW-1:0] ring_slot(logic [HW-1:0] b, logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(k);
    if (s >= SW'(HISTORY_DEPTH)) begin
      s = s - SW'(HISTORY_DEPTH);
    end
    return HW'(s);
  endfunction

  utb_ram #(.DEPTH(DOC_DEPTH), .WIDTH(8)) u_doc (
    .clk   (clk),
    .we    (doc_we),
    .waddr (doc_waddr),
    .wdata (doc_wdata),
    .raddr (doc_raddr),
    .rdata (doc_rdata)
  );

  utb_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(EW)) u_undo (
    .clk   (clk),
    .we    (undo_we),
    .waddr (undo_waddr),
    .wdata (undo_wdata),
    .raddr (undo_raddr),
    .rdata (undo_rdata)
  );

  utb_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(EW)) u_redo (
    .clk   (clk),
    .we    (redo_we),
    .waddr (redo_waddr),
    .wdata (redo_wdata),
    .raddr (redo_raddr),
    .rdata (redo_rdata)
  );

  // a full undo ring drops its oldest entry on a push
  assign undo_full     = 32'(undo_size) >= HISTORY_DEPTH;
  assign push_base     = !undo_full ? undo_base :
                         (undo_base == HW'(HISTORY_DEPTH - 1)) ? '0 : undo_base + 1'b1;
  assign push_cnt      = undo_full ? CW'(HISTORY_DEPTH - 1) : undo_size;
  assign push_slot     = ring_slot(push_base, push_cnt);
  assign undo_top_slot = ring_slot(undo_base, undo_size - 1'b1);
  assign fetched       = (op == utb_pkg::ACT_UNDO) ? utb_pkg::hist_t'(undo_rdata)
                                                   : utb_pkg::hist_t'(redo_rdata);

  assign busy = (state != utb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utb_pkg::S_IDLE;
      length    <= '0;
      undo_base <= '0;
      undo_size <= '0;
      redo_size <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      undo_base <= undo_base_next;
      undo_size <= undo_size_next;
      redo_size <= redo_size_next;
      done      <= done_next;
    end
    op       <= op_next;
    cur_pos  <= cur_pos_next;
    cur_ch   <= cur_ch_next;
    ent_kind <= ent_kind_next;
    put_op   <= put_op_next;
    idx      <= idx_next;
    result   <= result_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cur_pos_next   = cur_pos;
    cur_ch_next    = cur_ch;
    ent_kind_next  = ent_kind;
    put_op_next    = put_op;
    idx_next       = idx;
    length_next    = length;
    undo_base_next = undo_base;
    undo_size_next = undo_size;
    redo_size_next = redo_size;
    result_next    = result;
    done_next      = 1'b0;

    doc_we     = 1'b0;
    doc_waddr  = '0;
    doc_wdata  = '0;
    doc_raddr  = '0;
    undo_we    = 1'b0;
    undo_waddr = '0;
    undo_wdata = '0;
    undo_raddr = '0;
    redo_we    = 1'b0;
    redo_waddr = '0;
    redo_wdata = '0;
    redo_raddr = '0;

    fin        = 1'b0;
    fin_status = utb_pkg::STAT_OK;
    fin_ch     = '0;
    fin_pos    = '0;

    case (state)
      utb_pkg::S_IDLE: begin
        if (start) begin
          op_next      = cmd.action;
          cur_pos_next = cmd.position;
          cur_ch_next  = cmd.char_in;
          state_next   = utb_pkg::S_DISPATCH;
        end
      end

      utb_pkg::S_DISPATCH: begin
        case (op)
          utb_pkg::ACT_INSERT: begin
            put_op_next   = 1'b1;
            ent_kind_next = utb_pkg::KIND_INSERT;
            state_next    = utb_pkg::S_APPLY;
          end
          utb_pkg::ACT_DELETE: begin
            put_op_next   = 1'b0;
            ent_kind_next = utb_pkg::KIND_DELETE;
            state_next    = utb_pkg::S_APPLY;
          end
          utb_pkg::ACT_UNDO: begin
            if (undo_size == '0) begin
              fin        = 1'b1;
              fin_status = utb_pkg::STAT_EMPTY;
            end else begin
              undo_raddr = undo_top_slot;
              state_next = utb_pkg::S_FETCH;
            end
          end
          utb_pkg::ACT_REDO: begin
            if (redo_size == '0) begin
              fin        = 1'b1;
              fin_status = utb_pkg::STAT_EMPTY;
            end else begin
              redo_raddr = HW'(redo_size - 1'b1);
              state_next = utb_pkg::S_FETCH;
            end
          end
          utb_pkg::ACT_READ: begin
            if (32'(cur_pos) >= 32'(length)) begin
              fin        = 1'b1;
              fin_status = utb_pkg::STAT_RANGE;
            end else begin
              doc_raddr  = AW'(cur_pos);
              state_next = utb_pkg::S_READ_WAIT;
            end
          end
          default: begin
            // unknown action: no change, ok status, zero payload
            fin = 1'b1;
          end
        endcase
      end

      utb_pkg::S_FETCH: begin
        // undo replays an entry backward, redo forward
        ent_kind_next = fetched.kind;
        cur_pos_next  = fetched.pos;
        cur_ch_next   = fetched.ch;
        if (op == utb_pkg::ACT_UNDO) begin
          put_op_next = (fetched.kind == utb_pkg::KIND_DELETE);
        end else begin
          put_op_next = (fetched.kind == utb_pkg::KIND_INSERT);
        end
        state_next = utb_pkg::S_APPLY;
      end

      utb_pkg::S_APPLY: begin
        if (put_op) begin
          if (32'(cur_pos) > 32'(length)) begin
            fin        = 1'b1;
            fin_status = utb_pkg::STAT_RANGE;
          end else if (32'(length) >= DOC_DEPTH) begin
            fin        = 1'b1;
            fin_status = utb_pkg::STAT_FULL;
          end else if (32'(cur_pos) == 32'(length)) begin
            // append, no tail to move
            doc_we     = 1'b1;
            doc_waddr  = AW'(cur_pos);
            doc_wdata  = cur_ch;
            state_next = utb_pkg::S_COMMIT;
          end else begin
            // move the tail right, starting at the last byte
            idx_next   = length - 1'b1;
            doc_raddr  = AW'(length - 1'b1);
            state_next = utb_pkg::S_SHIFT;
          end
        end else begin
          if (32'(cur_pos) >= 32'(length)) begin
            fin        = 1'b1;
            fin_status = utb_pkg::STAT_RANGE;
          end else begin
            idx_next   = LW'(cur_pos);
            doc_raddr  = AW'(cur_pos);
            state_next = utb_pkg::S_TAKE_WAIT;
          end
        end
      end

      utb_pkg::S_TAKE_WAIT: begin
        // a plain delete reports the removed byte
        if (op == utb_pkg::ACT_DELETE) begin
          cur_ch_next = doc_rdata;
        end
        if (32'(idx) + 1 < 32'(length)) begin
          idx_next   = idx + 1'b1;
          doc_raddr  = AW'(idx + 1'b1);
          state_next = utb_pkg::S_SHIFT;
        end else begin
          state_next = utb_pkg::S_COMMIT;
        end
      end

      utb_pkg::S_SHIFT: begin
        // byte read last cycle lands one place over; reads and writes never meet
        doc_we    = 1'b1;
        doc_wdata = doc_rdata;
        if (put_op) begin
          doc_waddr = AW'(idx + 1'b1);
          if (32'(idx) == 32'(cur_pos)) begin
            state_next = utb_pkg::S_PUT_LAST;
          end else begin
            idx_next  = idx - 1'b1;
            doc_raddr = AW'(idx - 1'b1);
          end
        end else begin
          doc_waddr = AW'(idx - 1'b1);
          if (32'(idx) + 1 < 32'(length)) begin
            idx_next  = idx + 1'b1;
            doc_raddr = AW'(idx + 1'b1);
          end else begin
            state_next = utb_pkg::S_COMMIT;
          end
        end
      end

      utb_pkg::S_PUT_LAST: begin
        doc_we     = 1'b1;
        doc_waddr  = AW'(cur_pos);
        doc_wdata  = cur_ch;
        state_next = utb_pkg::S_COMMIT;
      end

      utb_pkg::S_READ_WAIT: begin
        fin     = 1'b1;
        fin_ch  = doc_rdata;
        fin_pos = cur_pos;
      end

      utb_pkg::S_COMMIT: begin
        length_next = put_op ? length + 1'b1 : length - 1'b1;
        fin         = 1'b1;
        case (op)
          utb_pkg::ACT_INSERT, utb_pkg::ACT_DELETE, utb_pkg::ACT_REDO: begin
            // record the edit on the undo ring
            undo_we        = 1'b1;
            undo_waddr     = push_slot;
            undo_wdata     = {ent_kind, cur_pos, cur_ch};
            undo_base_next = push_base;
            undo_size_next = push_cnt + 1'b1;
            redo_size_next = (op == utb_pkg::ACT_REDO) ? redo_size - 1'b1 : '0;
            fin_ch         = cur_ch;
            fin_pos        = cur_pos;
          end
          utb_pkg::ACT_UNDO: begin
            // a full redo stack leaves both stacks alone
            if (32'(redo_size) < HISTORY_DEPTH) begin
              undo_size_next = undo_size - 1'b1;
              redo_we        = 1'b1;
              redo_waddr     = HW'(redo_size);
              redo_wdata     = {ent_kind, cur_pos, cur_ch};
              redo_size_next = redo_size + 1'b1;
              fin_ch         = cur_ch;
              fin_pos        = cur_pos;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_next = utb_pkg::S_IDLE;
      end
    endcase

    // result beat carries the state after the command
    if (fin) begin
      result_next.status     = fin_status;
      result_next.char_out   = fin_ch;
      result_next.pos_out    = fin_pos;
      result_next.doc_length = utb_pkg::len_t'(length_next);
      result_next.undo_count = utb_pkg::count_t'(undo_size_next);
      result_next.redo_count = utb_pkg::count_t'(redo_size_next);
      done_next              = 1'b1;
      state_next             = utb_pkg::S_IDLE;
    end
  end

endmodule

// ----- design/utb_ram.sv -----
module utb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- test/tb_undoable_text_buffer.sv -----
`timescale 1ns / 100ps

module tb_undoable_text_buffer;

  localparam int DOC_DEPTH      = 256;
  localparam int HISTORY_DEPTH  = 64;
  localparam int ITEM_TARGET    = 1950;
  // longest correct silence: a full-length shift plus the longest sender gap
  localparam int WATCHDOG_LIMIT = 4000;
  // cycles to watch for stray result beats once nothing is owed
  localparam int TAIL_CYCLES    = 20;

  // shape of one stretch of random commands
  typedef enum {
    MIX_GROW,
    MIX_SHRINK,
    MIX_HISTORY,
    MIX_NOISE,
    MIX_FILL,
    MIX_UNWIND
  } mix_t;

  // mirror of the document and both edit stacks; owes one result per command
  class edit_ledger;
    utb_pkg::byte_t   doc [DOC_DEPTH];
    int unsigned      len = 0;
    utb_pkg::hist_t   undo_ring [HISTORY_DEPTH];
    int unsigned      undo_base = 0;
    int unsigned      undo_size = 0;
    utb_pkg::hist_t   redo_stack [HISTORY_DEPTH];
    int unsigned      redo_size = 0;
    utb_pkg::result_t owed_results [$];
    int               mismatches = 0;

    // insert with tail shift right
    function utb_pkg::status_t put_char(int unsigned pos, utb_pkg::byte_t ch);
      if (pos > len) return utb_pkg::STAT_RANGE;
      if (len >= DOC_DEPTH) return utb_pkg::STAT_FULL;
      for (int unsigned i = len; i > pos; i--) doc[i] = doc[i - 1];
      doc[pos] = ch;
      len++;
      return utb_pkg::STAT_OK;
    endfunction

    // removal with tail shift left, removed byte handed back
    function utb_pkg::status_t take_char(int unsigned pos, output utb_pkg::byte_t ch);
      ch = '0;
      if (pos >= len) return utb_pkg::STAT_RANGE;
      ch = doc[pos];
      for (int unsigned i = pos; i + 1 < len; i++) doc[i] = doc[i + 1];
      len--;
      return utb_pkg::STAT_OK;
    endfunction

    // a full history loses its oldest edit
    function void push_edit(utb_pkg::hist_t e);
      if (undo_size >= HISTORY_DEPTH) begin
        undo_base = (undo_base + 1) % HISTORY_DEPTH;
        undo_size = HISTORY_DEPTH - 1;
      end
      undo_ring[(undo_base + undo_size) % HISTORY_DEPTH] = e;
      undo_size++;
    endfunction

    function void record_command(utb_pkg::cmd_t c);
      utb_pkg::result_t r;
      utb_pkg::status_t st;
      utb_pkg::hist_t   e;
      utb_pkg::byte_t   taken;
      r  = '0;
      st = utb_pkg::STAT_OK;
      case (c.action)
        utb_pkg::ACT_INSERT: begin
          st = put_char(c.position, c.char_in);
          if (st == utb_pkg::STAT_OK) begin
            e = '{kind: utb_pkg::KIND_INSERT, pos: c.position, ch: c.char_in};
            push_edit(e);
            redo_size  = 0;
            r.char_out = c.char_in;
            r.pos_out  = c.position;
          end
        end
        utb_pkg::ACT_DELETE: begin
          st = take_char(c.position, taken);
          if (st == utb_pkg::STAT_OK) begin
            e = '{kind: utb_pkg::KIND_DELETE, pos: c.position, ch: taken};
            push_edit(e);
            redo_size  = 0;
            r.char_out = taken;
            r.pos_out  = c.position;
          end
        end
        utb_pkg::ACT_UNDO: begin
          if (undo_size == 0) begin
            st = utb_pkg::STAT_EMPTY;
          end else begin
            e = undo_ring[(undo_base + undo_size - 1) % HISTORY_DEPTH];
            if (e.kind == utb_pkg::KIND_INSERT) st = take_char(e.pos, taken);
            else st = put_char(e.pos, e.ch);
            if (st == utb_pkg::STAT_OK && redo_size < HISTORY_DEPTH) begin
              undo_size--;
              redo_stack[redo_size] = e;
              redo_size++;
              r.char_out = e.ch;
              r.pos_out  = e.pos;
            end
          end
        end
        utb_pkg::ACT_REDO: begin
          if (redo_size == 0) begin
            st = utb_pkg::STAT_EMPTY;
          end else begin
            e = redo_stack[redo_size - 1];
            if (e.kind == utb_pkg::KIND_INSERT) st = put_char(e.pos, e.ch);
            else st = take_char(e.pos, taken);
            if (st == utb_pkg::STAT_OK) begin
              redo_size--;
              push_edit(e);
              r.char_out = e.ch;
              r.pos_out  = e.pos;
            end
          end
        end
        utb_pkg::ACT_READ: begin
          if (c.position >= len) begin
            st = utb_pkg::STAT_RANGE;
          end else begin
            r.char_out = doc[c.position];
            r.pos_out  = c.position;
          end
        end
        default: ;
      endcase
      r.status     = st;
      r.doc_length = utb_pkg::len_t'(len);
      r.undo_count = utb_pkg::count_t'(undo_size);
      r.redo_count = utb_pkg::count_t'(redo_size);
      owed_results.push_back(r);
    endfunction

    function void check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(utb_pkg::result_t got);
      utb_pkg::result_t want;
      if (owed_results.size() == 0) begin
        $error("result beat with no command pending");
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("char_out", want.char_out, got.char_out);
      check_field("pos_out", want.pos_out, got.pos_out);
      check_field("doc_length", want.doc_length, got.doc_length);
      check_field("undo_count", want.undo_count, got.undo_count);
      check_field("redo_count", want.redo_count, got.redo_count);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  utb_pkg::cmd_t    cmd;
  logic             done;
  utb_pkg::result_t result;

  edit_ledger ledger = new();
  int         sent = 0;       // command beats that do something
  int         idle_pct = 25;  // chance of a sender gap before a beat
  int         quiet_cycles = 0;

  undoable_text_buffer #(
    .DOC_DEPTH    (DOC_DEPTH),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  always #1 clk = ~clk;

  // result beats are one cycle wide and cannot be held off
  always @(posedge clk) begin
    if (!rst && done === 1'b1) ledger.match_result(result);
  end

  // watchdog: silence on both channels for too long means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic utb_pkg::cmd_t cmd_of(utb_pkg::action_t a, int unsigned p,
                                           int unsigned ch);
    utb_pkg::cmd_t c;
    c.action   = a;
    c.position = utb_pkg::byte_t'(p);
    c.char_in  = utb_pkg::byte_t'(ch);
    return c;
  endfunction

  // random command with mostly valid positions for the current document
  function automatic utb_pkg::cmd_t next_cmd(mix_t m);
    int unsigned      roll;
    int unsigned      p;
    utb_pkg::action_t a;
    roll = $urandom_range(99);
    case (m)
      MIX_GROW:
        a = roll < 75 ? utb_pkg::ACT_INSERT : roll < 85 ? utb_pkg::ACT_DELETE :
            roll < 95 ? utb_pkg::ACT_READ : roll < 98 ? utb_pkg::ACT_UNDO : utb_pkg::ACT_REDO;
      MIX_SHRINK:
        a = roll < 70 ? utb_pkg::ACT_DELETE : roll < 80 ? utb_pkg::ACT_INSERT :
            roll < 95 ? utb_pkg::ACT_READ : utb_pkg::ACT_UNDO;
      MIX_HISTORY:
        a = roll < 45 ? utb_pkg::ACT_UNDO : roll < 80 ? utb_pkg::ACT_REDO :
            roll < 87 ? utb_pkg::ACT_INSERT : roll < 92 ? utb_pkg::ACT_DELETE :
            utb_pkg::ACT_READ;
      default:
        a = utb_pkg::action_t'($urandom_range(7));
    endcase
    // a few positions anywhere, so out-of-range ones keep turning up
    if (m == MIX_NOISE || $urandom_range(99) < 8) p = $urandom_range(255);
    else if (a == utb_pkg::ACT_INSERT)
      p = (ledger.len > 255) ? $urandom_range(255) : $urandom_range(ledger.len);
    else p = (ledger.len == 0) ? 0 : $urandom_range(ledger.len - 1);
    return cmd_of(a, p, $urandom_range(255));
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send(input utb_pkg::cmd_t c);
    int gap;
    // sender idling: light, then heavy, then none
    if (sent < ITEM_TARGET / 3) idle_pct = 25;
    else if (sent < 2 * ITEM_TARGET / 3) idle_pct = 80;
    else idle_pct = 0;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(19) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // start may rise while busy, the beat then lands as busy drops
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.record_command(c);
    if (c.action <= utb_pkg::ACT_READ) sent++;
    @(negedge clk);
  endtask

  initial begin
    mix_t        m;
    int unsigned roll;
    int unsigned run;
    bit          filled_once;
    filled_once = 1'b0;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty document and empty stacks first
    send(cmd_of(utb_pkg::ACT_READ, 0, 0));
    send(cmd_of(utb_pkg::ACT_DELETE, 0, 0));
    send(cmd_of(utb_pkg::ACT_UNDO, 0, 0));
    send(cmd_of(utb_pkg::ACT_REDO, 0, 0));
    send(cmd_of(utb_pkg::ACT_INSERT, 1, 8'h11));     // beyond the end
    // build a short document: end, front and middle inserts, byte extremes
    send(cmd_of(utb_pkg::ACT_INSERT, 0, 8'h00));
    send(cmd_of(utb_pkg::ACT_INSERT, 1, 8'hff));
    send(cmd_of(utb_pkg::ACT_INSERT, 0, 8'ha5));
    send(cmd_of(utb_pkg::ACT_INSERT, 1, 8'h5a));
    send(cmd_of(utb_pkg::ACT_READ, 0, 0));
    send(cmd_of(utb_pkg::ACT_READ, 3, 0));
    send(cmd_of(utb_pkg::ACT_READ, 4, 0));           // one past the end
    send(cmd_of(utb_pkg::ACT_READ, 255, 8'hff));
    send(cmd_of(utb_pkg::ACT_DELETE, 3, 0));         // last byte
    send(cmd_of(utb_pkg::ACT_DELETE, 0, 0));         // first byte
    send(cmd_of(utb_pkg::ACT_UNDO, 0, 0));
    send(cmd_of(utb_pkg::ACT_UNDO, 0, 0));
    send(cmd_of(utb_pkg::ACT_REDO, 0, 0));
    // a fresh edit throws the redo stack away
    send(cmd_of(utb_pkg::ACT_INSERT, 0, 8'h3c));
    send(cmd_of(utb_pkg::ACT_REDO, 0, 0));
    // unused action codes do nothing
    send(cmd_of(3'd5, 0, 0));
    send(cmd_of(3'd6, 255, 255));
    send(cmd_of(3'd7, 8'haa, 8'h55));
    send(cmd_of(utb_pkg::ACT_DELETE, 255, 0));
    send(cmd_of(utb_pkg::ACT_INSERT, 255, 8'h81));

    // random stretches; one full-document pass is forced by mid-run
    while (sent < ITEM_TARGET) begin
      if (!filled_once && sent >= ITEM_TARGET / 2) begin
        m = MIX_FILL;
      end else begin
        roll = $urandom_range(99);
        m = roll < 30 ? MIX_GROW : roll < 50 ? MIX_SHRINK : roll < 72 ? MIX_HISTORY :
            roll < 84 ? MIX_NOISE : roll < 92 ? MIX_UNWIND : MIX_FILL;
      end
      case (m)
        MIX_FILL: begin
          // grow to capacity, then knock on the full document
          filled_once = 1'b1;
          while (ledger.len < DOC_DEPTH)
            send(cmd_of(utb_pkg::ACT_INSERT, $urandom_range(ledger.len), $urandom_range(255)));
          repeat (3)
            send(cmd_of(utb_pkg::ACT_INSERT, $urandom_range(255), $urandom_range(255)));
        end
        MIX_UNWIND: begin
          // drain the undo stack past empty, then replay some or all of it
          while (ledger.undo_size != 0)
            send(cmd_of(utb_pkg::ACT_UNDO, $urandom_range(255), $urandom_range(255)));
          repeat (2)
            send(cmd_of(utb_pkg::ACT_UNDO, $urandom_range(255), $urandom_range(255)));
          run = $urandom_range(1) ? ledger.redo_size + 1 : $urandom_range(ledger.redo_size);
          repeat (run)
            send(cmd_of(utb_pkg::ACT_REDO, $urandom_range(255), $urandom_range(255)));
        end
        default: begin
          run = $urandom_range(20, 100);
          repeat (run) send(next_cmd(m));
        end
      endcase
    end
    start <= 1'b0;

    // drain, then watch a little longer for stray beats
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
